/* sv/dtr_pkg.sv */
// Shared types, codes and helpers for the divider/timer block.
// Used by dtr_core and divider_timer_with_delayed_reload; no dependencies.
`default_nettype none

package dtr_pkg;

	typedef logic [1:0] op_t;
	typedef logic [1:0] sel_t;

	localparam op_t OP_TICK  = 2'd0;
	localparam op_t OP_WRITE = 2'd1;
	localparam op_t OP_READ  = 2'd2;

	localparam sel_t SEL_DIVIDER = 2'd0;
	localparam sel_t SEL_COUNTER = 2'd1;
	localparam sel_t SEL_MODULO  = 2'd2;
	localparam sel_t SEL_CONTROL = 2'd3;

	localparam logic [2:0] SPAN_START      = 3'd5;
	localparam logic [7:0] CTRL_READ_ONES  = 8'hF8;
	localparam logic [7:0] COUNTER_MAX     = 8'hFF;

	// Pick the divider tap for a rate select: bits 9, 3, 5, 7.
	function automatic logic tap_bit(input logic [15:0] div, input logic [1:0] rate);
		logic b;
		case (rate)
			2'd0:    b = div[9];
			2'd1:    b = div[3];
			2'd2:    b = div[5];
			default: b = div[7];
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

/* sv/divider_timer_with_delayed_reload.sv */
// An accepted request waits in the input stage until the result register can take it.
// Throughput: one request per cycle; the input stage refills whenever the
//   result register is empty or being taken in the same cycle.
// The state update and result select sit between the input and result registers.
// Reset: arst_n clears all timer registers and both valid flags at once.
// Depends on dtr_pkg and dtr_core.
`default_nettype none

module divider_timer_with_delayed_reload (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] operation,
	input  wire logic [1:0] reg_select,
	input  wire logic [7:0] write_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      read_data,
	output logic            timer_irq
);

	// input stage
	logic               valid_s1;
	dtr_pkg::op_t       op_s1;
	dtr_pkg::sel_t      sel_s1;
	logic [7:0]         data_s1;

	// result register
	logic               out_valid_q;
	logic [7:0]         read_data_q;
	logic               timer_irq_q;

	logic               advance;
	logic [7:0]         rd_c;
	logic               irq_c;

	// Advance the held request when the result register can take its result.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the request payload on accept.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= operation;
			sel_s1  <= reg_select;
			data_s1 <= write_data;
		end
	end

	// Timer state is committed only when the request moves on, so requests
	// take effect strictly in order.
	dtr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.operation  (op_s1),
		.reg_select (sel_s1),
		.write_data (data_s1),
		.read_data  (rd_c),
		.timer_irq  (irq_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result until taken.
	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rd_c;
			timer_irq_q <= irq_c;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign timer_irq = timer_irq_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked result");
	a_irq_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && timer_irq_q |-> read_data_q == 8'd0)
		else $error("interrupt result carries read data");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced request produced no result");

endmodule

`default_nettype wire

/* sv/dtr_core.sv */
// Timer register file and next-state logic for one request per cycle in which fire is high.
// Depends on dtr_pkg.
`default_nettype none

module dtr_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire dtr_pkg::op_t  operation,
	input  wire dtr_pkg::sel_t reg_select,
	input  wire logic [7:0]    write_data,
	output logic [7:0]         read_data,
	output logic               timer_irq
);

	logic [15:0] div_q;
	logic [7:0]  cnt_q;
	logic [7:0]  mod_q;
	logic [2:0]  ctrl_q;
	logic        prev_q;
	logic [2:0]  od_q;
	logic [2:0]  rw_q;

	logic [15:0] div_n;
	logic [7:0]  cnt_n;
	logic [7:0]  mod_n;
	logic [2:0]  ctrl_n;
	logic        prev_n;
	logic [2:0]  od_n;
	logic [2:0]  rw_n;

	logic [15:0] div_inc;
	logic        tap;
	logic        fall;
	logic [7:0]  cnt_a;
	logic [2:0]  od_a;
	logic [2:0]  od_b;
	logic [2:0]  rw_a;
	logic        irq_t;

	// tick path
	always_comb begin
		div_inc = div_q + 16'd1;
		tap     = dtr_pkg::tap_bit(div_inc, ctrl_q[1:0]) & ctrl_q[2];
		fall    = (od_q == 3'd0) && !tap && prev_q;
		cnt_a   = fall ? cnt_q + 8'd1 : cnt_q;
		od_a    = (fall && cnt_q == dtr_pkg::COUNTER_MAX) ? dtr_pkg::SPAN_START : od_q;
		od_b    = (od_a != 3'd0) ? od_a - 3'd1 : od_a;
		irq_t   = (od_a != 3'd0) && (od_b == 3'd0);
		rw_a    = irq_t ? dtr_pkg::SPAN_START : rw_q;
	end

	always_comb begin
		div_n     = div_q;
		cnt_n     = cnt_q;
		mod_n     = mod_q;
		ctrl_n    = ctrl_q;
		prev_n    = prev_q;
		od_n      = od_q;
		rw_n      = rw_q;
		read_data = 8'd0;
		timer_irq = 1'b0;
		case (operation)
			dtr_pkg::OP_TICK: begin
				div_n     = div_inc;
				prev_n    = tap;
				od_n      = od_b;
				timer_irq = irq_t;
				if (rw_a != 3'd0) begin
					rw_n  = rw_a - 3'd1;
					cnt_n = mod_q;
				end else begin
					rw_n  = rw_a;
					cnt_n = cnt_a;
				end
			end
			dtr_pkg::OP_WRITE: begin
				unique case (reg_select)
					dtr_pkg::SEL_DIVIDER: div_n = 16'd0;
					dtr_pkg::SEL_COUNTER: begin
						if (rw_q == 3'd0) begin
							od_n  = 3'd0;
							cnt_n = write_data;
						end
					end
					dtr_pkg::SEL_MODULO:  mod_n  = write_data;
					default:              ctrl_n = write_data[2:0];
				endcase
			end
			dtr_pkg::OP_READ: begin
				unique case (reg_select)
					dtr_pkg::SEL_DIVIDER: read_data = div_q[15:8];
					dtr_pkg::SEL_COUNTER: read_data = cnt_q;
					dtr_pkg::SEL_MODULO:  read_data = mod_q;
					default:              read_data = dtr_pkg::CTRL_READ_ONES | {5'd0, ctrl_q};
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q  <= '0;
			cnt_q  <= '0;
			mod_q  <= '0;
			ctrl_q <= '0;
			prev_q <= 1'b0;
			od_q   <= '0;
			rw_q   <= '0;
		end else if (fire) begin
			div_q  <= div_n;
			cnt_q  <= cnt_n;
			mod_q  <= mod_n;
			ctrl_q <= ctrl_n;
			prev_q <= prev_n;
			od_q   <= od_n;
			rw_q   <= rw_n;
		end
	end

	a_irq_opens_window: assert property (@(posedge clk) disable iff (!arst_n)
		fire && timer_irq |=> rw_q == 3'd4)
		else $error("reload window not opened after interrupt");
	a_delay_bound: assert property (@(posedge clk) disable iff (!arst_n)
		od_q <= 3'd4)
		else $error("overflow delay out of range");
	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rw_q <= 3'd4)
		else $error("reload window out of range");

endmodule

`default_nettype wire
